/* rtl/two_channel_tone_sequencer_top_defines.svh */
// assertion macros for the two-channel tone sequencer
`ifndef TWO_CHANNEL_TONE_SEQUENCER_TOP_DEFINES_SVH
`define TWO_CHANNEL_TONE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCS_ASSERT_NOW(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("tone sequencer check failed");

// next-cycle implication, checked out of reset
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tone sequencer check failed");

`endif

/* rtl/tcs_pkg.sv */
// types, codes and step functions of the two-channel tone sequencer
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int STEP_DEPTH_DEF  = 256;
    localparam int SOUND_COUNT_DEF = 16;
    localparam int WORD_W          = 25;

    localparam logic [15:0] EOS   = 16'd0;
    localparam logic [15:0] PAUSE = 16'd1;
    localparam logic [15:0] LOOP  = 16'd2;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_NEXT = 3'b010,
        MODE_WAIT = 3'b100
    } mode_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RD1  = 4'b0010,
        PH_RD2  = 4'b0100,
        PH_FIN  = 4'b1000
    } phase_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  base;
        logic [7:0]  offset;
        logic [7:0]  timer;
        logic        running;
        logic [15:0] reload;
    } chan_t;

    function automatic chan_t apply_cmd(chan_t c, logic start, logic ent_valid,
                                        logic [7:0] ent_base, logic stop);
        chan_t r;
        r = c;
        if (r.timer != 8'd0)
        begin
            r.timer = r.timer - 8'd1;
        end
        if (start && ent_valid)
        begin
            r.base   = ent_base;
            r.offset = 8'd0;
            r.mode   = MODE_NEXT;
        end
        if (stop)
        begin
            r.running = 1'b0;
            r.mode    = MODE_IDLE;
        end
        return r;
    endfunction

    function automatic chan_t apply_step(chan_t c, logic [WORD_W-1:0] w);
        chan_t       r;
        logic [15:0] rl;
        logic [7:0]  dur;
        logic        leg;
        r   = c;
        rl  = w[15:0];
        dur = w[23:16];
        leg = w[24];
        unique case (c.mode)
            MODE_NEXT:
            begin
                if (rl == PAUSE)
                begin
                    r.timer = dur;
                    r.mode  = MODE_WAIT;
                end
                else if (rl == EOS)
                begin
                    r.running = 1'b0;
                    r.mode    = MODE_IDLE;
                end
                else if (rl == LOOP)
                begin
                    r.offset = 8'd0;
                end
                else
                begin
                    r.reload  = rl;
                    r.running = 1'b1;
                    if (dur == 8'd0)
                    begin
                        r.offset = c.offset + 8'd1;
                    end
                    else
                    begin
                        r.timer = dur;
                        r.mode  = MODE_WAIT;
                    end
                end
            end
            MODE_WAIT:
            begin
                if (c.timer == 8'd0)
                begin
                    if (!(leg || rl == PAUSE))
                    begin
                        r.running = 1'b0;
                    end
                    r.offset = c.offset + 8'd1;
                    r.mode   = MODE_NEXT;
                end
            end
            default:
            begin
                r = c;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/two_channel_tone_sequencer_top.sv */
// two-channel tone sequencer: step memory, start tables and channel sequencing
//
// input channel (in_valid/in_ready) carries one word per action: a tick with
// start/stop commands, a step memory load or a start table load; loads give
// no result word
// a tick decrements both note timers, applies the commands, then reads the
// shared step memory for channel 1 and then for channel 2 (one read port,
// registered read data) and updates each channel from its word
// a tick gives one result word on the output channel (out_valid/out_ready)
// after phases RD1, RD2 and FIN, through the output register; the next word is
// accepted in the cycle the result is loaded, never while a tick still reads
// the output register holds its word while out_ready is low; a finished tick
// then waits and in_ready stays low until the register frees up
// reset clears channel state and start table valid bits at once; step memory
// holds no reset value and must be loaded before a sequence uses it
// STEP_DEPTH must be a power of two; the block does not enforce this
`timescale 1ns / 1ps
`include "two_channel_tone_sequencer_top_defines.svh"

module two_channel_tone_sequencer_top #(
    parameter int STEP_DEPTH  = tcs_pkg::STEP_DEPTH_DEF,
    parameter int SOUND_COUNT = tcs_pkg::SOUND_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  sound_number,
    input  logic        start_one,
    input  logic        start_two,
    input  logic        stop_one,
    input  logic        stop_two,
    input  logic [7:0]  step_address,
    input  logic [15:0] step_reload,
    input  logic [7:0]  step_duration,
    input  logic        step_legato,
    input  logic        start_channel,
    input  logic        start_valid,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tone_one_on,
    output logic [15:0] tone_one_reload,
    output logic        tone_two_on,
    output logic [15:0] tone_two_reload,
    output logic        one_busy,
    output logic        two_busy
);

    localparam int AW        = $clog2(STEP_DEPTH);
    localparam int SW        = (AW > 9) ? AW : 9;
    localparam int TBL_DEPTH = (SOUND_COUNT < 16) ? SOUND_COUNT : 16;
    localparam int TW        = $clog2(TBL_DEPTH);

    logic [tcs_pkg::WORD_W-1:0] step_mem [STEP_DEPTH];
    logic [tcs_pkg::WORD_W-1:0] rdata_reg;

    logic             tbl_valid_reg [2][TBL_DEPTH];
    logic [7:0]       tbl_base_reg  [2][TBL_DEPTH];

    tcs_pkg::chan_t   chan_reg  [2];
    tcs_pkg::chan_t   chan_next [2];
    tcs_pkg::phase_t  phase_reg, phase_next;

    logic             out_valid_reg;
    logic             tone_one_on_reg, tone_two_on_reg;
    logic [15:0]      tone_one_reload_reg, tone_two_reload_reg;
    logic             one_busy_reg, two_busy_reg;

    logic             accept, load_out, can_load, sound_ok;
    logic [TW-1:0]    tbl_idx;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [SW-1:0]    wr_ext;

    function automatic logic [AW-1:0] addr_of(tcs_pkg::chan_t c);
        logic [8:0]    sum;
        logic [SW-1:0] ext;
        sum = {1'b0, c.base} + {1'b0, c.offset};
        ext = SW'(sum);
        return ext[AW-1:0];
    endfunction

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = (phase_reg == tcs_pkg::PH_IDLE) ||
                      ((phase_reg == tcs_pkg::PH_FIN) && can_load);
    assign accept   = in_valid && in_ready;
    assign load_out = (phase_reg == tcs_pkg::PH_FIN) && can_load;
    assign sound_ok = (32'(sound_number) < SOUND_COUNT);
    assign tbl_idx  = sound_number[TW-1:0];
    assign wr_ext   = SW'(step_address);
    assign wr_addr  = wr_ext[AW-1:0];

    always_comb
    begin
        chan_next[0] = chan_reg[0];
        chan_next[1] = chan_reg[1];
        rd_addr      = addr_of(chan_reg[1]);
        phase_next   = phase_reg;
        unique case (phase_reg)
            tcs_pkg::PH_IDLE, tcs_pkg::PH_FIN:
            begin
                if (phase_reg == tcs_pkg::PH_FIN && !can_load)
                begin
                    phase_next = tcs_pkg::PH_FIN;
                end
                else if (accept && action == tcs_pkg::ACT_TICK)
                begin
                    chan_next[0] = tcs_pkg::apply_cmd(chan_reg[0], start_one && sound_ok,
                                                      tbl_valid_reg[0][tbl_idx],
                                                      tbl_base_reg[0][tbl_idx], stop_one);
                    chan_next[1] = tcs_pkg::apply_cmd(chan_reg[1], start_two && sound_ok,
                                                      tbl_valid_reg[1][tbl_idx],
                                                      tbl_base_reg[1][tbl_idx], stop_two);
                    rd_addr      = addr_of(chan_next[0]);
                    phase_next   = tcs_pkg::PH_RD1;
                end
                else
                begin
                    phase_next = tcs_pkg::PH_IDLE;
                end
            end
            tcs_pkg::PH_RD1:
            begin
                chan_next[0] = tcs_pkg::apply_step(chan_reg[0], rdata_reg);
                rd_addr      = addr_of(chan_reg[1]);
                phase_next   = tcs_pkg::PH_RD2;
            end
            tcs_pkg::PH_RD2:
            begin
                chan_next[1] = tcs_pkg::apply_step(chan_reg[1], rdata_reg);
                phase_next   = tcs_pkg::PH_FIN;
            end
            default:
            begin
                phase_next = tcs_pkg::PH_IDLE;
            end
        endcase
    end

    // step memory, at most one write and one read per cycle
    always_ff @(posedge clk)
    begin
        if (accept && action == tcs_pkg::ACT_STEP)
        begin
            step_mem[wr_addr] <= {step_legato, step_duration, step_reload};
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= step_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < TBL_DEPTH; i++)
                begin
                    tbl_valid_reg[c][i] <= 1'b0;
                end
            end
        end
        else if (accept && action == tcs_pkg::ACT_START && sound_ok)
        begin
            tbl_valid_reg[start_channel][tbl_idx] <= start_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && action == tcs_pkg::ACT_START && sound_ok)
        begin
            tbl_base_reg[start_channel][tbl_idx] <= step_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tcs_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                chan_reg[c].mode    <= tcs_pkg::MODE_IDLE;
                chan_reg[c].base    <= 8'd0;
                chan_reg[c].offset  <= 8'd0;
                chan_reg[c].timer   <= 8'd0;
                chan_reg[c].running <= 1'b0;
                chan_reg[c].reload  <= 16'd0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            chan_reg[0] <= chan_next[0];
            chan_reg[1] <= chan_next[1];
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            tone_one_on_reg     <= chan_reg[0].running;
            tone_one_reload_reg <= chan_reg[0].reload;
            tone_two_on_reg     <= chan_reg[1].running;
            tone_two_reload_reg <= chan_reg[1].reload;
            one_busy_reg        <= (chan_reg[0].mode != tcs_pkg::MODE_IDLE);
            two_busy_reg        <= (chan_reg[1].mode != tcs_pkg::MODE_IDLE);
        end
    end

    assign out_valid       = out_valid_reg;
    assign tone_one_on     = tone_one_on_reg;
    assign tone_one_reload = tone_one_reload_reg;
    assign tone_two_on     = tone_two_on_reg;
    assign tone_two_reload = tone_two_reload_reg;
    assign one_busy        = one_busy_reg;
    assign two_busy        = two_busy_reg;

    `TCS_ASSERT_NOW(a_no_accept_mid_tick, clk, rst_n,
        (phase_reg == tcs_pkg::PH_RD1 || phase_reg == tcs_pkg::PH_RD2), !in_ready)
    `TCS_ASSERT_NEXT(a_tick_reads_ch1, clk, rst_n,
        (accept && action == tcs_pkg::ACT_TICK), (phase_reg == tcs_pkg::PH_RD1))
    `TCS_ASSERT_NEXT(a_fin_waits_on_stall, clk, rst_n,
        (phase_reg == tcs_pkg::PH_FIN && out_valid_reg && !out_ready),
        (phase_reg == tcs_pkg::PH_FIN && out_valid_reg))
    `TCS_ASSERT_NEXT(a_result_follows_fin, clk, rst_n, load_out, out_valid_reg)

endmodule
